// File: hw/rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared sizes, command codes, handshake structs and the victim compare
// used by the LFU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam int NUM_ENTRIES = 16;
	localparam int IDX_W       = $clog2(NUM_ENTRIES);
	localparam int OCC_W       = IDX_W + 1;
	localparam int CAP_W       = 5;
	localparam int KEY_W       = 32;
	localparam int DATA_W      = 32;
	localparam int CNT_W       = 32;
	localparam int S_TDATA_W   = 64;
	localparam int M_TDATA_W   = 40;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(NUM_ENTRIES);
	localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(NUM_ENTRIES);

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take_in;
		logic look;
		logic pick;
		logic commit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} dp_status_t;

	// One candidate in the victim search.
	typedef struct packed {
		logic              vld;
		logic [IDX_W-1:0]  idx;
		logic [CNT_W-1:0]  cnt;
		logic [IDX_W-1:0]  rank;
	} cand_t;

	// The better victim of two: valid, lower use count, then older touch.
	// On a full tie the first argument, the lower slot, wins.
	function automatic cand_t pick_better(input cand_t a, input cand_t b);
		logic a_wins;
		a_wins = a.vld && (!b.vld || (a.cnt < b.cnt) ||
			((a.cnt == b.cnt) && (a.rank >= b.rank)));
		return a_wins ? a : b;
	endfunction

endpackage

// File: hw/rtl/lfu_key_value_cache_top.sv
// ----------------------------------------------------------------------------
// lfu_key_value_cache_top
// Results: a result word appears on m_tvalid once its request has passed the
//   lookup, victim pick and write-back stages, later if the previous result
//   is still held.
// Requests: the sequencer walks one request through its three stages before
//   it takes the next.
// Reset: arst_n clears all entries to invalid and sets the capacity to 16.
// ----------------------------------------------------------------------------
module lfu_key_value_cache_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Request channel.
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [lkvc_pkg::S_TDATA_W-1:0]        s_tdata,  // lookup_key[31:0], write_value[63:32]
	input  logic                                  s_tuser,  // cmd: 0 get, 1 put
	// Result channel.
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [lkvc_pkg::M_TDATA_W-1:0]        m_tdata,  // read_value[31:0], evicted[32], zero pad
	output logic                                  m_tuser,  // hit
	// Capacity register.
	input  logic                                  cfg_we,
	input  logic [lkvc_pkg::CAP_W-1:0]            cfg_wdata
);

	// The controller sequences each request; the datapath holds all entries,
	// the match and victim logic, and a one-word output register, so a result
	// may wait for m_tready while the next request is already being looked up.
	lkvc_pkg::ctrl_cmd_t  cmd;
	lkvc_pkg::dp_status_t status;

	// Sequencer: IDLE takes a word, LOOK matches the key across all entries
	// and reduces the victim candidates to four, PICK finishes the victim,
	// WRITE updates the entries and loads the result once the output is free.
	lkvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// The victim is the valid entry with the lowest use count, and among
	// those the one touched longest ago (highest recency rank). A capacity
	// above the entry count acts as the entry count; zero ignores puts.
	lkvc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

// File: hw/rtl/lkvc_ctrl.sv
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Request sequencer: take a word, look up, pick the victim, write back.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  lkvc_pkg::dp_status_t   status,
	output lkvc_pkg::ctrl_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_LOOK  = 2'd1;
	localparam logic [1:0] ST_PICK  = 2'd2;
	localparam logic [1:0] ST_WRITE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		state_nxt   = state_q;
		cmd.take_in = 1'b0;
		cmd.look    = 1'b0;
		cmd.pick    = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.take_in = 1'b1;
					state_nxt   = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.look  = 1'b1;
				state_nxt = ST_PICK;
			end
			ST_PICK: begin
				cmd.pick  = 1'b1;
				state_nxt = ST_WRITE;
			end
			ST_WRITE: begin
				// Hold here while the previous result still sits unread.
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign s_tready = (state_q == ST_IDLE);

endmodule

// File: hw/rtl/lkvc_dp.sv
// ----------------------------------------------------------------------------
// lkvc_dp
// Entry storage, parallel key match, two-stage victim tree, write-back
// and the output register.
// ----------------------------------------------------------------------------
module lkvc_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  lkvc_pkg::ctrl_cmd_t                   cmd,
	output lkvc_pkg::dp_status_t                  status,
	input  logic [lkvc_pkg::S_TDATA_W-1:0]        s_tdata,
	input  logic                                  s_tuser,
	input  logic                                  cfg_we,
	input  logic [lkvc_pkg::CAP_W-1:0]            cfg_wdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [lkvc_pkg::M_TDATA_W-1:0]        m_tdata,
	output logic                                  m_tuser
);

	localparam int N = lkvc_pkg::NUM_ENTRIES;

	// Entry storage.
	logic [N-1:0]                     valid_q;
	logic [lkvc_pkg::KEY_W-1:0]       key_q   [N];
	logic [lkvc_pkg::DATA_W-1:0]      data_q  [N];
	logic [lkvc_pkg::CNT_W-1:0]       cnt_q   [N];
	logic [lkvc_pkg::IDX_W-1:0]       rank_q  [N];
	logic [lkvc_pkg::CAP_W-1:0]       cap_q;

	// Request registers.
	logic                             cmd_q;
	logic [lkvc_pkg::KEY_W-1:0]       in_key_q;
	logic [lkvc_pkg::DATA_W-1:0]      in_val_q;

	// Lookup stage.
	logic                             hit_s1;
	logic [lkvc_pkg::IDX_W-1:0]       hidx_s1;
	logic [lkvc_pkg::IDX_W-1:0]       hrank_s1;
	logic [lkvc_pkg::DATA_W-1:0]      hdata_s1;
	logic [lkvc_pkg::OCC_W-1:0]       occ_s1;
	lkvc_pkg::cand_t                  cand_s1 [4];

	// Victim stage.
	lkvc_pkg::cand_t                  vic_s2;

	// Output register.
	logic                             out_valid_q;
	logic                             out_hit_q;
	logic [lkvc_pkg::DATA_W-1:0]      out_read_q;
	logic                             out_evict_q;

	// ---------------- lookup ----------------
	logic                             hit_c;
	logic [lkvc_pkg::IDX_W-1:0]       hidx_c;
	logic [lkvc_pkg::OCC_W-1:0]       occ_c;
	lkvc_pkg::cand_t                  lvl0 [N];
	lkvc_pkg::cand_t                  lvl1 [N/2];
	lkvc_pkg::cand_t                  lvl2 [N/4];

	always_comb begin
		hit_c  = 1'b0;
		hidx_c = '0;
		occ_c  = '0;
		for (int j = N - 1; j >= 0; j--) begin
			if (valid_q[j] && (key_q[j] == in_key_q)) begin
				hit_c  = 1'b1;
				hidx_c = lkvc_pkg::IDX_W'(j);
			end
		end
		for (int j = 0; j < N; j++) begin
			occ_c = occ_c + lkvc_pkg::OCC_W'(valid_q[j]);
		end
		for (int j = 0; j < N; j++) begin
			lvl0[j].vld  = valid_q[j];
			lvl0[j].idx  = lkvc_pkg::IDX_W'(j);
			lvl0[j].cnt  = cnt_q[j];
			lvl0[j].rank = rank_q[j];
		end
		for (int j = 0; j < N / 2; j++) begin
			lvl1[j] = lkvc_pkg::pick_better(lvl0[2*j], lvl0[2*j+1]);
		end
		for (int j = 0; j < N / 4; j++) begin
			lvl2[j] = lkvc_pkg::pick_better(lvl1[2*j], lvl1[2*j+1]);
		end
	end

	// ---------------- victim finish ----------------
	lkvc_pkg::cand_t lvl3 [2];
	lkvc_pkg::cand_t vic_c;

	always_comb begin
		lvl3[0] = lkvc_pkg::pick_better(cand_s1[0], cand_s1[1]);
		lvl3[1] = lkvc_pkg::pick_better(cand_s1[2], cand_s1[3]);
		vic_c   = lkvc_pkg::pick_better(lvl3[0], lvl3[1]);
	end

	// ---------------- write-back ----------------
	logic [lkvc_pkg::CAP_W-1:0]       cap_eff;
	logic                             is_get;
	logic                             do_touch;
	logic                             do_insert;
	logic                             do_evict;
	logic [N-1:0]                     valid_after;
	logic                             slot_ok;
	logic [lkvc_pkg::IDX_W-1:0]       slot;
	logic [N-1:0]                     valid_nxt;
	logic [lkvc_pkg::CNT_W-1:0]       cnt_nxt  [N];
	logic [lkvc_pkg::IDX_W-1:0]       rank_nxt [N];
	logic [N-1:0]                     data_we;
	logic [N-1:0]                     key_we;
	logic [lkvc_pkg::DATA_W-1:0]      read_c;

	always_comb begin
		cap_eff   = (cap_q > lkvc_pkg::CAP_MAX) ? lkvc_pkg::CAP_MAX : cap_q;
		is_get    = (cmd_q == lkvc_pkg::CMD_GET);
		do_touch  = hit_s1 && (is_get || (cap_eff != '0));
		do_insert = !hit_s1 && !is_get && (cap_eff != '0);
		do_evict  = do_insert && (occ_s1 >= lkvc_pkg::OCC_W'(cap_eff)) && vic_s2.vld;

		valid_after = valid_q;
		if (do_evict) begin
			valid_after[vic_s2.idx] = 1'b0;
		end

		slot_ok = 1'b0;
		slot    = '0;
		for (int j = N - 1; j >= 0; j--) begin
			if (!valid_after[j]) begin
				slot_ok = 1'b1;
				slot    = lkvc_pkg::IDX_W'(j);
			end
		end

		valid_nxt = valid_q;
		data_we   = '0;
		key_we    = '0;
		for (int j = 0; j < N; j++) begin
			cnt_nxt[j]  = cnt_q[j];
			rank_nxt[j] = rank_q[j];
			if (do_touch) begin
				if (lkvc_pkg::IDX_W'(j) == hidx_s1) begin
					rank_nxt[j] = '0;
					if (cnt_q[j] != '1) begin
						cnt_nxt[j] = cnt_q[j] + lkvc_pkg::CNT_W'(1);
					end
					data_we[j] = !is_get;
				end else if (valid_q[j] && (rank_q[j] < hrank_s1)) begin
					rank_nxt[j] = rank_q[j] + lkvc_pkg::IDX_W'(1);
				end
			end
			if (do_insert) begin
				valid_nxt[j] = valid_after[j];
				// Entries above the victim close the gap and all age by one,
				// so they keep their rank.
				if (valid_after[j] && !(do_evict && (rank_q[j] > vic_s2.rank))) begin
					rank_nxt[j] = rank_q[j] + lkvc_pkg::IDX_W'(1);
				end
				if (slot_ok && (lkvc_pkg::IDX_W'(j) == slot)) begin
					valid_nxt[j] = 1'b1;
					cnt_nxt[j]   = lkvc_pkg::CNT_W'(1);
					rank_nxt[j]  = '0;
					data_we[j]   = 1'b1;
					key_we[j]    = 1'b1;
				end
			end
		end

		if (!is_get) begin
			read_c = '0;
		end else if (hit_s1) begin
			read_c = hdata_s1;
		end else begin
			read_c = '1;
		end
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			cap_q       <= lkvc_pkg::CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				valid_q <= valid_nxt;
			end
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			cmd_q    <= s_tuser;
			in_key_q <= s_tdata[lkvc_pkg::KEY_W-1:0];
			in_val_q <= s_tdata[lkvc_pkg::KEY_W +: lkvc_pkg::DATA_W];
		end
		if (cmd.look) begin
			hit_s1   <= hit_c;
			hidx_s1  <= hidx_c;
			hrank_s1 <= rank_q[hidx_c];
			hdata_s1 <= data_q[hidx_c];
			occ_s1   <= occ_c;
			for (int j = 0; j < N / 4; j++) begin
				cand_s1[j] <= lvl2[j];
			end
		end
		if (cmd.pick) begin
			vic_s2 <= vic_c;
		end
		if (cmd.commit) begin
			for (int j = 0; j < N; j++) begin
				cnt_q[j]  <= cnt_nxt[j];
				rank_q[j] <= rank_nxt[j];
				if (data_we[j]) begin
					data_q[j] <= in_val_q;
				end
				if (key_we[j]) begin
					key_q[j] <= in_key_q;
				end
			end
			out_hit_q   <= hit_s1;
			out_read_q  <= read_c;
			out_evict_q <= do_evict;
		end
	end

	assign status.out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_hit_q;
	assign m_tdata  = {(lkvc_pkg::M_TDATA_W - lkvc_pkg::DATA_W - 1)'(0),
		out_evict_q, out_read_q};

endmodule

// File: hw/rtl/lkvc_checker.sv
// ----------------------------------------------------------------------------
// lkvc_checker
// Port-level checks for the LFU key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lkvc_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	input  logic                                  s_tready,
	input  logic                                  m_tvalid,
	input  logic                                  m_tready,
	input  logic [lkvc_pkg::M_TDATA_W-1:0]        m_tdata,
	input  logic                                  m_tuser
);

	logic       in_acc;
	logic       out_acc;
	logic [1:0] pend_q;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// Requests taken minus results delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	// A held result keeps its word.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// One request in work at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("request taken while another is in work");

	// No result without a request, and at most one waiting plus one in work.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (pend_q != 2'd0) && (pend_q != 2'd3))
		else $error("result count does not match request count");

	// Only a put miss evicts, and a put reads back zero.
	a_evict_put_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[lkvc_pkg::DATA_W] |-> !m_tuser &&
			(m_tdata[lkvc_pkg::DATA_W-1:0] == '0))
		else $error("eviction reported on a hit or a get");

endmodule

bind lfu_key_value_cache_top lkvc_checker u_lkvc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
